// ===== sv/rwc_pkg.sv =====
// shared types and constants of the rolling window checksum unit
package rwc_pkg;

   localparam int WindowMax = 1024;
   localparam int PtrWidth  = $clog2(WindowMax);
   localparam int FillWidth = PtrWidth + 1;
   localparam int SumWidth  = 16;
   localparam int ByteWidth = 8;
   localparam int FuncWidth = 2;
   localparam int CsumWidth = 2 * SumWidth;
   localparam int ProdWidth = FillWidth + ByteWidth;

   localparam logic [FillWidth-1:0] WindowMaxVal = FillWidth'(WindowMax);
   localparam logic [FillWidth-1:0] WindowLenReset = FillWidth'(WindowMax);

   typedef enum logic [FuncWidth-1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_APPEND = 2'd1,
      FUNC_DROP   = 2'd2
   } func_type;

   // what the sum stage does with the byte read from the ring
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_CLEAR,
      OP_GROW,
      OP_ROLL,
      OP_DROP
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [ByteWidth-1:0]   data_byte;
      logic [FillWidth-1:0]   weight;
      logic [FillWidth-1:0]   fill;
      logic                   full;
      logic                   ignored;
   } stage_type;

endpackage

// ===== sv/rwc_if.sv =====
// channel interfaces of the rolling window checksum unit

interface rwc_req_if;
   logic                          valid;
   logic                          ready;
   logic [rwc_pkg::FuncWidth-1:0] func;
   logic [rwc_pkg::ByteWidth-1:0] data_byte;

   modport source (output valid, output func, output data_byte, input ready);
   modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface rwc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rwc_pkg::CsumWidth-1:0] checksum;
   logic [rwc_pkg::FillWidth-1:0] window_fill;
   logic                          window_full;
   logic                          ignored;

   modport source (output valid, output checksum, output window_fill, output window_full,
                   output ignored, input ready);
   modport sink   (input valid, input checksum, input window_fill, input window_full,
                   input ignored, output ready);
endinterface

interface rwc_csr_if;
   logic                          valid;
   logic                          ready;
   logic [rwc_pkg::FillWidth-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/rwc_ram.sv =====
// generic single-clock ram, one write and one registered read port, read-first
module rwc_ram #(
   parameter int Width = 8,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/rolling_window_checksum_unit.sv =====
// rolling window checksum unit: top level
//
// req carries func (clear, append, drop) and data_byte; every transfer on req
// yields exactly one transfer on rsp with the checksum (high sum in the upper
// half, low sum in the lower half), the fill, the full flag and the ignored
// flag of a drop on an empty window. csr writes the window length; it is
// always ready, and a length of 0 acts as 1, one above 1024 as 1024.
// The window bytes sit in a 1024 x 8 ram. In the cycle of the req transfer
// the pointer and fill are updated and the ram is read at the oldest byte
// (roll, drop) and written with the new one (append; read-first, so a rolling
// append sees the byte it replaces). In the next cycle the byte comes out of the
// ram, and when the sum stage moves the sums are updated (one 11 x 8 multiply,
// adds) into the rsp register. Throughput: one item per cycle while rsp is not
// stalled, set by the single ram read per item.
// Reset clears sums, pointer, fill and the length (back to 1024); the ram is
// not cleared, only bytes inside the fill are ever read.
// When the receiver stalls rsp holds; one more item is taken into the sum
// stage, then req.ready drops until rsp moves.
module rolling_window_checksum_unit (
   input logic clock,
   input logic reset,
   rwc_req_if.sink   req,
   rwc_rsp_if.source rsp,
   rwc_csr_if.sink   csr
);
   import rwc_pkg::*;

   logic [FillWidth-1:0] len_ff, len_in;
   logic [PtrWidth-1:0]  ptr_ff, ptr_in;
   logic [FillWidth-1:0] fill_ff, fill_in;
   logic [SumWidth-1:0]  low_ff, low_in;
   logic [SumWidth-1:0]  high_ff, high_in;
   logic                 s1_valid_ff, s1_valid_in;
   stage_type            s1_ff, s1_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CsumWidth-1:0] csum_ff;
   logic [FillWidth-1:0] rsp_fill_ff;
   logic                 rsp_full_ff;
   logic                 rsp_ign_ff;

   logic                 req_fire;
   logic                 out_free;
   logic                 s1_move;
   logic                 ram_wr_en;
   logic [PtrWidth-1:0]  ram_wr_addr;
   logic                 ram_rd_en;
   logic [ByteWidth-1:0] old_byte;
   logic [FillWidth-1:0] ptr_plus_fill;
   logic [ProdWidth-1:0] product;
   logic [SumWidth-1:0]  weighted;
   logic [SumWidth-1:0]  byte_ext;
   logic [SumWidth-1:0]  old_ext;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req.ready = !s1_valid_ff || out_free;
   assign req_fire  = req.valid && req.ready;
   assign csr.ready = 1'b1;

   // length register holds the clamped value
   always_comb begin
      len_in = len_ff;
      if (csr.valid) begin
         if (csr.data == '0) begin
            len_in = FillWidth'(1);
         end else if (csr.data > WindowMaxVal) begin
            len_in = WindowMaxVal;
         end else begin
            len_in = csr.data;
         end
      end
   end

   assign ptr_plus_fill = {1'b0, ptr_ff} + fill_ff;

   // pointer, fill and ring access in the transfer cycle
   always_comb begin
      ptr_in            = ptr_ff;
      fill_in           = fill_ff;
      ram_wr_en         = 1'b0;
      ram_wr_addr       = ptr_ff;
      ram_rd_en         = 1'b0;
      s1_in.op          = OP_HOLD;
      s1_in.data_byte   = req.data_byte;
      s1_in.weight      = fill_ff;
      s1_in.ignored     = 1'b0;
      if (req_fire) begin
         unique case (req.func)
            FUNC_CLEAR: begin
               ptr_in   = '0;
               fill_in  = '0;
               s1_in.op = OP_CLEAR;
            end
            FUNC_APPEND: begin
               if (fill_ff < len_ff) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = ptr_plus_fill[PtrWidth-1:0];
                  fill_in     = fill_ff + FillWidth'(1);
                  s1_in.op    = OP_GROW;
               end else begin
                  ram_wr_en = 1'b1;
                  ram_rd_en = 1'b1;
                  ptr_in    = ptr_ff + PtrWidth'(1);
                  s1_in.op  = OP_ROLL;
               end
            end
            FUNC_DROP: begin
               if (fill_ff == '0) begin
                  s1_in.ignored = 1'b1;
               end else begin
                  ram_rd_en = 1'b1;
                  ptr_in    = ptr_ff + PtrWidth'(1);
                  fill_in   = fill_ff - FillWidth'(1);
                  s1_in.op  = OP_DROP;
               end
            end
            default: begin
               s1_in.op = OP_HOLD;
            end
         endcase
      end
      s1_in.fill = fill_in;
      s1_in.full = (fill_in >= len_ff);
   end

   assign s1_valid_in = req_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);

   rwc_ram #(
      .Width(ByteWidth),
      .Depth(WindowMax)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(req.data_byte),
      .rd_en  (ram_rd_en),
      .rd_addr(ptr_ff),
      .rd_data(old_byte)
   );

   // sum stage: the ring byte arrives in the cycle after the transfer
   assign product  = {{(ProdWidth-FillWidth){1'b0}}, s1_ff.weight}
                   * {{(ProdWidth-ByteWidth){1'b0}}, old_byte};
   assign weighted = product[SumWidth-1:0];
   assign byte_ext = {{(SumWidth-ByteWidth){1'b0}}, s1_ff.data_byte};
   assign old_ext  = {{(SumWidth-ByteWidth){1'b0}}, old_byte};

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (s1_move) begin
         case (s1_ff.op)
            OP_CLEAR: begin
               low_in  = '0;
               high_in = '0;
            end
            OP_GROW: begin
               low_in  = low_ff + byte_ext;
               high_in = high_ff + low_in;
            end
            OP_ROLL: begin
               low_in  = low_ff - old_ext + byte_ext;
               high_in = high_ff + low_in - weighted;
            end
            OP_DROP: begin
               low_in  = low_ff - old_ext;
               high_in = high_ff - weighted;
            end
            default: begin
               low_in  = low_ff;
               high_in = high_ff;
            end
         endcase
      end
   end

   assign rsp_valid_in = s1_move ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= WindowLenReset;
         ptr_ff       <= '0;
         fill_ff      <= '0;
         low_ff       <= '0;
         high_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         ptr_ff       <= ptr_in;
         fill_ff      <= fill_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= s1_in;
      end
      if (s1_move) begin
         csum_ff     <= {high_in, low_in};
         rsp_fill_ff <= s1_ff.fill;
         rsp_full_ff <= s1_ff.full;
         rsp_ign_ff  <= s1_ff.ignored;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.checksum    = csum_ff;
   assign rsp.window_fill = rsp_fill_ff;
   assign rsp.window_full = rsp_full_ff;
   assign rsp.ignored     = rsp_ign_ff;

endmodule

// ===== sv/rwc_checker.sv =====
// port-level checks of the rolling window checksum unit, bound to the top level
module rwc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [rwc_pkg::CsumWidth-1:0] rsp_checksum,
   input logic [rwc_pkg::FillWidth-1:0] rsp_window_fill,
   input logic                          rsp_window_full,
   input logic                          rsp_ignored
);
   import rwc_pkg::*;

   // a stalled result keeps its checksum, fill and ignored flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_checksum)
         && $stable(rsp_window_fill) && $stable(rsp_ignored))
      else $error("rsp payload changed while stalled");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_window_fill <= WindowMaxVal)
      else $error("window fill above maximum");

   // a drop is only ignored on an empty window
   a_ignored_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ignored |-> rsp_window_fill == '0 && !rsp_window_full)
      else $error("ignored drop with a nonempty window");

   // length is at least one, so an empty window is never full
   a_full_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_window_full |-> rsp_window_fill != '0)
      else $error("full flag on an empty window");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind rolling_window_checksum_unit rwc_checker u_rwc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_checksum   (rsp.checksum),
   .rsp_window_fill(rsp.window_fill),
   .rsp_window_full(rsp.window_full),
   .rsp_ignored    (rsp.ignored)
);
